@@ design/ssd_stereo_block_matcher_defines.svh @@
// Assertion helpers for the SSD stereo matcher.
`ifndef SSD_STEREO_BLOCK_MATCHER_DEFINES_SVH
`define SSD_STEREO_BLOCK_MATCHER_DEFINES_SVH

// Implication check, reset-qualified.
`define SSD_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication check, reset-qualified.
`define SSD_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ design/ssd_pkg.sv @@
package ssd_pkg;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HALF    = 8;
    localparam int MAX_OFFSETS = 32;
    localparam int MAX_HEIGHT  = 2048;
    localparam int RING_ROWS   = 2 * MAX_HALF;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int RING_W      = $clog2(RING_ROWS);
    localparam int ADDR_W      = RING_W + COL_W;
    localparam int POS_W       = 11;
    localparam int OFF_W       = 6;
    localparam int HALF_W      = 5;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HALF   = 2'd2;
    localparam logic [1:0] REG_OFFS   = 2'd3;

    // Job handed from front to back: window origin and search setup.
    typedef struct packed {
        logic [POS_W-1:0]  row0;
        logic [POS_W-1:0]  col0;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic [HALF_W-1:0] n;
        logic [OFF_W-1:0]  kmax;
        logic [7:0]        scale;
    } job_t;

    // floor(255/d), d in 1..MAX_OFFSETS; constant table
    function automatic logic [7:0] scale_of(input logic [OFF_W-1:0] d);
        logic [7:0] r;
        unique case (d)
            6'd1:  r = 8'd255;  6'd2:  r = 8'd127;  6'd3:  r = 8'd85;   6'd4:  r = 8'd63;
            6'd5:  r = 8'd51;   6'd6:  r = 8'd42;   6'd7:  r = 8'd36;   6'd8:  r = 8'd31;
            6'd9:  r = 8'd28;   6'd10: r = 8'd25;   6'd11: r = 8'd23;   6'd12: r = 8'd21;
            6'd13: r = 8'd19;   6'd14: r = 8'd18;   6'd15: r = 8'd17;   6'd16: r = 8'd15;
            6'd17: r = 8'd15;   6'd18: r = 8'd14;   6'd19: r = 8'd13;   6'd20: r = 8'd12;
            6'd21: r = 8'd12;   6'd22: r = 8'd11;   6'd23: r = 8'd11;   6'd24: r = 8'd10;
            6'd25: r = 8'd10;   6'd26: r = 8'd9;    6'd27: r = 8'd9;    6'd28: r = 8'd9;
            6'd29: r = 8'd8;    6'd30: r = 8'd8;    6'd31: r = 8'd8;    6'd32: r = 8'd7;
            default: r = 8'd0;
        endcase
        return r;
    endfunction
endpackage

@@ design/ssd_front.sv @@
module ssd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          left_pixel,
    input  logic [7:0]          right_pixel,
    input  logic                frame_start,
    input  logic                busy,
    output logic                st_we,
    output logic [ssd_pkg::ADDR_W-1:0] st_addr,
    output logic [7:0]          st_left,
    output logic [7:0]          st_right,
    output logic                job_valid,
    input  logic                job_ready,
    output ssd_pkg::job_t       job
);
    import ssd_pkg::*;

    logic [11:0] width_reg, height_reg;
    logic [3:0]  half_reg;
    logic [5:0]  offs_reg;
    logic [11:0] row_reg, col_reg;
    logic [11:0] jrow_reg;
    logic [11:0] w, hgt, r0, r, c, nr, nc;
    logic [HALF_W-1:0] h, n;
    logic [OFF_W-1:0] d;
    logic        interior, acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            half_reg   <= 4'd1;
            offs_reg   <= 6'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_HALF:   half_reg   <= cfg_data[3:0];
                REG_OFFS:   offs_reg   <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        w   = (width_reg < 12'd4) ? 12'd4
            : (width_reg > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_reg;
        hgt = (height_reg < 12'd4) ? 12'd4
            : (height_reg > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : height_reg;
        h   = (half_reg == 4'd0) ? 5'd1 : (half_reg > 4'(MAX_HALF)) ? 5'(MAX_HALF)
            : {1'b0, half_reg};
        d   = (offs_reg == 6'd0) ? 6'd1 : (offs_reg > 6'(MAX_OFFSETS)) ? 6'(MAX_OFFSETS)
            : offs_reg;
        n   = 5'(h << 1);
        r0  = frame_start ? 12'd0 : row_reg;
        c   = frame_start ? 12'd0 : col_reg;
        if (c >= w)
        begin
            c  = 12'd0;
            r0 = r0 + 12'd1;
        end
        r  = (r0 >= hgt) ? 12'd0 : r0;
        nc = c + 12'd1;
        nr = r;
        if (nc >= w)
        begin
            nc = 12'd0;
            nr = (r + 12'd1 >= hgt) ? 12'd0 : r + 12'd1;
        end
        interior = (r >= 12'(n)) && (r + 12'd2 <= hgt) && (c >= 12'(n)) && (c + 12'd2 <= w);
    end

    // While a search is pending, only pixels on the row of the pending jobs
    // go in; a new row would overwrite ring rows still inside their windows.
    assign in_ready = job_ready && (!busy || (r == jrow_reg));
    assign acc      = in_valid && in_ready;
    assign st_we    = acc;
    assign st_addr  = {r[RING_W-1:0], c[COL_W-1:0]};
    assign st_left  = left_pixel;
    assign st_right = right_pixel;
    assign job_valid = acc && interior;

    always_comb
    begin
        job.row0    = POS_W'(r - 12'(n) + 12'd1);
        job.col0    = POS_W'(c - 12'(n) + 12'd1);
        job.out_row = POS_W'(r - 12'(h) + 12'd1);
        job.out_col = POS_W'(c - 12'(h) + 12'd1);
        job.n       = n;
        job.kmax    = ((12'(d) - 12'd1) > (c - 12'(n) + 12'd1)) ? OFF_W'(c - 12'(n) + 12'd1)
                    : d - 6'd1;
        job.scale   = scale_of(d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 12'd0;
            col_reg  <= 12'd0;
            jrow_reg <= 12'd0;
        end
        else if (acc)
        begin
            row_reg <= nr;
            col_reg <= nc;
            if (interior) jrow_reg <= r;
        end
    end
endmodule

@@ design/ssd_queue.sv @@
module ssd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ssd_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ssd_pkg::job_t rd_job
);
    import ssd_pkg::*;
    `include "ssd_stereo_block_matcher_defines.svh"

    job_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    `SSD_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= 2'(QDEPTH))
    `SSD_ASSERT_NXT(a_q_fill, clk, rst_n, wr && !rd, cnt_reg == $past(cnt_reg) + 2'd1)
    `SSD_ASSERT_IMP(a_q_ptr, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'(QDEPTH),
        wp_reg == rp_reg)
endmodule

@@ design/ssd_back.sv @@
module ssd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          st_we,
    input  logic [ssd_pkg::ADDR_W-1:0] st_addr,
    input  logic [7:0]    st_left,
    input  logic [7:0]    st_right,
    input  logic          job_valid,
    output logic          job_ready,
    input  ssd_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [10:0]   out_row,
    output logic [10:0]   out_col,
    output logic [7:0]    disparity_code
);
    import ssd_pkg::*;
    `include "ssd_stereo_block_matcher_defines.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [7:0] lmem [RING_ROWS*MAX_WIDTH];
    logic [7:0] rmem [RING_ROWS*MAX_WIDTH];

    logic [1:0]        state_reg, state_next;
    job_t              job_reg;
    logic [HALF_W-1:0] v_reg, u_reg;
    logic [OFF_W-1:0]  k_reg;
    logic [23:0]       sum_reg, best_reg;
    logic [OFF_W-1:0]  bestk_reg;
    logic              rvld_reg, rvld2_reg, rlast_reg, rlast2_reg;
    logic [OFF_W-1:0]  rk_reg, rk2_reg;
    logic [7:0]        lq_reg, rq_reg;
    logic [15:0]       sq_reg;
    logic              ovalid_reg;
    logic [10:0]       orow_reg, ocol_reg;
    logic [7:0]        ocode_reg;
    logic [POS_W-1:0]  ra, lca, rca;
    logic              issue, last_u, last_v, last_k;
    logic signed [8:0] diff;
    logic [23:0]       tot;

    assign ra  = job_reg.row0 + POS_W'(v_reg);
    assign lca = job_reg.col0 + POS_W'(u_reg);
    assign rca = lca - POS_W'(k_reg);
    assign issue  = (state_reg == S_RUN);
    assign last_u = (u_reg == job_reg.n - 5'd1);
    assign last_v = (v_reg == job_reg.n - 5'd1);
    assign last_k = (k_reg == job_reg.kmax);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            lmem[st_addr] <= st_left;
            rmem[st_addr] <= st_right;
        end
        lq_reg <= lmem[{ra[RING_W-1:0], lca[COL_W-1:0]}];
        rq_reg <= rmem[{ra[RING_W-1:0], rca[COL_W-1:0]}];
    end

    assign job_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (job_valid) state_next = S_RUN;
            S_RUN:  if (last_u && last_v && last_k) state_next = S_DONE;
            S_DONE: if (!rvld_reg && !rvld2_reg && !ovalid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign diff = $signed({1'b0, lq_reg}) - $signed({1'b0, rq_reg});
    assign tot  = sum_reg + 24'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvld_reg   <= 1'b0;
            rvld2_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rvld_reg  <= issue;
            rvld2_reg <= rvld_reg;
            if (rvld2_reg && rlast2_reg && (rk2_reg == job_reg.kmax)) ovalid_reg <= 1'b1;
            else if (out_valid && out_ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid)
        begin
            job_reg <= job;
            v_reg   <= '0;
            u_reg   <= '0;
            k_reg   <= '0;
            sum_reg <= '0;
        end
        else if (issue)
        begin
            if (!last_u) u_reg <= u_reg + 5'd1;
            else
            begin
                u_reg <= '0;
                if (!last_v) v_reg <= v_reg + 5'd1;
                else
                begin
                    v_reg <= '0;
                    k_reg <= k_reg + 6'd1;
                end
            end
        end
        rlast_reg  <= last_u && last_v;
        rk_reg     <= k_reg;
        rlast2_reg <= rlast_reg;
        rk2_reg    <= rk_reg;
        sq_reg     <= 16'(diff * diff);
        if (rvld2_reg)
        begin
            if (rlast2_reg)
            begin
                sum_reg <= '0;
                if (rk2_reg == 6'd0 || tot < best_reg)
                begin
                    best_reg  <= tot;
                    bestk_reg <= rk2_reg;
                end
            end
            else
                sum_reg <= tot;
        end
        if (rvld2_reg && rlast2_reg && (rk2_reg == job_reg.kmax))
        begin
            orow_reg  <= job_reg.out_row;
            ocol_reg  <= job_reg.out_col;
            // Multiply only once per pixel; the final tie check picks the index.
            ocode_reg <= (rk2_reg == 6'd0 || tot < best_reg)
                       ? 8'(rk2_reg * job_reg.scale) : 8'(bestk_reg * job_reg.scale);
        end
    end

    assign out_valid      = ovalid_reg;
    assign out_row        = orow_reg;
    assign out_col        = ocol_reg;
    assign disparity_code = ocode_reg;

    `SSD_ASSERT_IMP(a_b_idle, clk, rst_n, state_reg == S_IDLE,
        !rvld_reg && !rvld2_reg && !ovalid_reg)
    `SSD_ASSERT_NXT(a_b_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SSD_ASSERT_IMP(a_b_k, clk, rst_n, issue, k_reg <= job_reg.kmax)
endmodule

@@ design/ssd_stereo_block_matcher.sv @@
// Result: the back end sweeps the (2h)^2 window pixels for each of K offsets,
//   K = offsets searched (at most offset_count), then registers the result.
// Flow: the back end takes no new job until its result word is taken;
//   a pixel on a new row waits until the search drains.
// Reset: async active low; position counters clear, registers take
//   640/480/1/4, line stores are not cleared.
module ssd_stereo_block_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  left_pixel,
    input  logic [7:0]  right_pixel,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] out_row,
    output logic [10:0] out_col,
    output logic [7:0]  disparity_code
);
    import ssd_pkg::*;

    // Front: position tracking, store writes, interior decision.
    logic              st_we;
    logic [ADDR_W-1:0] st_addr;
    logic [7:0]        st_left, st_right;
    logic              fj_valid, fj_ready, bj_valid, bj_ready;
    logic              bk_busy;
    job_t              fj, bj;

    // Search pending anywhere behind the front: queued job or back not idle.
    assign bk_busy = bj_valid || !bj_ready;

    ssd_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .left_pixel, .right_pixel, .frame_start,
        .busy(bk_busy),
        .st_we, .st_addr, .st_left, .st_right,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    // Short job queue so the front keeps storing while the back searches.
    ssd_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    // Back: SSD search over offsets, result register.
    ssd_back u_back (
        .clk, .rst_n, .st_we, .st_addr, .st_left, .st_right,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid, .out_ready, .out_row, .out_col, .disparity_code
    );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Testbench for ssd_stereo_block_matcher.
// Pixel words are queued by the stimulus block and offered by a driver at the
// falling edge. Each accepted word goes through a disparity predictor that
// keeps its own line stores, raster position and register copies. Result
// words are checked field by field against the queue of predicted disparities.
module tb;
    import ssd_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;  // covers a 16x16 window over 32 offsets, plus stalls
    localparam int ITEM_TARGET    = 1900;
    localparam int STORE_SIZE     = 16 * 2048;

    typedef struct {
        logic [7:0] left;
        logic [7:0] right;
        logic       fs;
    } pixel_word_t;

    typedef struct {
        logic [10:0] row;
        logic [10:0] col;
        logic [7:0]  code;
    } disparity_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  left_pixel;
    logic [7:0]  right_pixel;
    logic        frame_start;
    logic        out_valid;
    logic        out_ready;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  disparity_code;

    ssd_stereo_block_matcher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_pixel     (left_pixel),
        .right_pixel    (right_pixel),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .disparity_code (disparity_code)
    );

    // stimulus -> driver, predictor -> checker
    pixel_word_t     pixel_q[$];
    disparity_word_t disparity_q[$];

    // predictor state
    logic [7:0] left_store[STORE_SIZE];
    logic [7:0] right_store[STORE_SIZE];
    int unsigned raster_row, raster_col;
    int unsigned reg_width, reg_height, reg_half, reg_offsets;

    int  n_queued, n_accepted, n_results, n_errors, n_phases, stall_cycles;
    int  rx_hold;          // receiver hold-off, counted down by the receiver
    bit  steady;           // no random idling on either side
    bit  word_taken;       // in-flight pixel word accepted at last rising edge

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned clamp_val(int unsigned v, int unsigned lo,
                                              int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int store_slot(int unsigned row, int unsigned col);
        return (row % 16) * 2048 + (col % 2048);
    endfunction

    // Store the pixel pair, advance the raster, and predict the disparity of
    // the window that this pixel completes, if any.
    function automatic void predict_disparity(pixel_word_t p);
        int unsigned w, hg, h, d, n, r, c, row0, col0;
        int unsigned best_k, best_sum, sum, k, v, u;
        int a, b;
        disparity_word_t res;
        w  = clamp_val(reg_width, 4, 2048);
        hg = clamp_val(reg_height, 4, 2048);
        h  = clamp_val(reg_half, 1, 8);
        d  = clamp_val(reg_offsets, 1, 32);
        n  = 2 * h;
        if (p.fs)
        begin
            raster_row = 0;
            raster_col = 0;
        end
        if (raster_col >= w)
        begin
            raster_col = 0;
            raster_row++;
        end
        if (raster_row >= hg)
            raster_row = 0;
        r = raster_row;
        c = raster_col;
        left_store[store_slot(r, c)]  = p.left;
        right_store[store_slot(r, c)] = p.right;
        if (r >= n && r + 2 <= hg && c >= n && c + 2 <= w)
        begin
            row0 = r - n + 1;
            col0 = c - n + 1;
            best_k = 0;
            best_sum = 0;
            // offsets reaching left of column 0 are skipped
            for (k = 0; k < d && k <= col0; k++)
            begin
                sum = 0;
                for (v = 0; v < n; v++)
                    for (u = 0; u < n; u++)
                    begin
                        a = left_store[store_slot(row0 + v, col0 + u)];
                        b = right_store[store_slot(row0 + v, col0 + u - k)];
                        sum += (a - b) * (a - b);
                    end
                if (k == 0 || sum < best_sum)
                begin
                    best_sum = sum;
                    best_k = k;
                end
            end
            res.row  = 11'(r - h + 1);
            res.col  = 11'(c - h + 1);
            res.code = 8'(best_k * (255 / d));
            disparity_q = {disparity_q, res};
        end
        raster_col = c + 1;
        if (raster_col >= w)
        begin
            raster_col = 0;
            raster_row = r + 1;
            if (raster_row >= hg)
                raster_row = 0;
        end
    endfunction

    // Rising edge: acceptance, prediction, result check, watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_disparity('{left_pixel, right_pixel, frame_start});
                word_taken = 1'b1;
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (disparity_q.size() == 0)
                begin
                    $display("%0t: unexpected result word row=%0d col=%0d code=%0d",
                             $time, out_row, out_col, disparity_code);
                    n_errors++;
                end
                else
                begin
                    disparity_word_t e;
                    e = disparity_q.pop_front();
                    if (out_row !== e.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
                        n_errors++;
                    end
                    if (out_col !== e.col)
                    begin
                        $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
                        n_errors++;
                    end
                    if (disparity_code !== e.code)
                    begin
                        $display("%0t: disparity_code expected %0d actual %0d (row %0d col %0d)",
                                 $time, e.code, disparity_code, e.row, e.col);
                        n_errors++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, disparity_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Sender: new word at the falling edge once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 38))
            begin
                pixel_word_t p;
                p = pixel_q.pop_front();
                left_pixel  <= p.left;
                right_pixel <= p.right;
                frame_start <= p.fs;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, or a counted hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_WIDTH:  reg_width   = val;
            REG_HEIGHT: reg_height  = val;
            REG_HALF:   reg_half    = val[3:0];
            REG_OFFS:   reg_offsets = val[5:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int w, int hg, int h, int d);
        write_reg(REG_WIDTH, 12'(w));
        write_reg(REG_HEIGHT, 12'(hg));
        write_reg(REG_HALF, 12'(h));
        write_reg(REG_OFFS, 12'(d));
    endtask

    // Wait until every queued word is taken and every disparity has come,
    // then let trailing border pixels drain.
    task automatic wait_drained();
        while (n_accepted != n_queued || disparity_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        n_phases++;
    endtask

    // Queue count pixel words for rows of width w. Mode 0: right image is the
    // left one shifted by a per-row disparity plus noise, some rows pure noise,
    // rare stray frame starts. Mode 1: left checkerboard of 0 and 255, right in runs of three words.
    task automatic queue_pixels(int w, int count, bit fs_first, int mode);
        logic [7:0] left_row[];
        int col, dsp, noise;
        pixel_word_t p;
        left_row = new[w + 40];
        col = 0;
        dsp = 0;
        noise = 0;
        for (int t = 0; t < count; t++)
        begin
            if (col == 0)
            begin
                foreach (left_row[x])
                    left_row[x] = 8'($urandom);
                dsp = $urandom_range(0, 31);
                noise = ($urandom_range(7) == 0);
            end
            if (mode == 1)
            begin
                p.left  = ((t + t / w) & 1) ? 8'd255 : 8'd0;
                p.right = ((t / 3) & 1) ? 8'd0 : 8'd255;
            end
            else
            begin
                p.left  = left_row[col];
                p.right = noise ? 8'($urandom)
                                : 8'(left_row[col + dsp] ^ 8'($urandom_range(0, 3)));
            end
            p.fs = (t == 0) ? fs_first : ($urandom_range(399) == 0);
            pixel_q = {pixel_q, p};
            n_queued++;
            col = (col + 1 == w) ? 0 : col + 1;
        end
    endtask

    initial
    begin
        int w, hg, h, d, frames, cnt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        left_pixel = '0;
        right_pixel = '0;
        frame_start = 1'b0;
        out_ready = 1'b0;
        word_taken = 1'b0;
        steady = 1'b0;
        rx_hold = 0;
        n_queued = 0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;
        n_phases = 0;
        stall_cycles = 0;
        raster_row = 0;
        raster_col = 0;
        reg_width = 640;
        reg_height = 480;
        reg_half = 1;
        reg_offsets = 4;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: a few border pixels on row 0
        queue_pixels(640, 20, 1'b1, 0);
        wait_drained();

        // extreme pixel values, single offset
        set_geometry(6, 6, 1, 1);
        queue_pixels(6, 36, 1'b1, 1);
        wait_drained();

        // out-of-range register values are clamped: 2048 x 4, h=1, D=1
        set_geometry(4095, 0, 0, 0);
        queue_pixels(2048, 12, 1'b1, 0);
        wait_drained();

        // largest window and offset count (h 15 -> 8, D 63 -> 32)
        set_geometry(20, 18, 15, 63);
        queue_pixels(20, 360, 1'b1, 0);
        wait_drained();

        // widest left-edge skipping at small size, no idling on either side
        steady = 1'b1;
        set_geometry(24, 8, 1, 32);
        queue_pixels(24, 24 * 8, 1'b1, 0);
        wait_drained();
        steady = 1'b0;

        // long receiver hold while the sender keeps offering words
        set_geometry(12, 10, 1, 8);
        rx_hold = 400;
        queue_pixels(12, 240, 1'b1, 0);
        wait_drained();

        // width shrinks mid-row without a frame start: position wraps
        set_geometry(16, 9, 1, 5);
        queue_pixels(16, 16 * 9 + 13, 1'b1, 0);
        wait_drained();
        write_reg(REG_WIDTH, 12'd9);
        queue_pixels(9, 60, 1'b0, 0);
        wait_drained();

        // random geometries; mostly small windows to keep the run short
        while (n_queued < ITEM_TARGET)
        begin
            if ($urandom_range(9) == 0)
            begin
                h = $urandom_range(3, 8);
                d = $urandom_range(1, 6);
            end
            else
            begin
                h = $urandom_range(1, 2);
                d = $urandom_range(1, 32);
            end
            w  = $urandom_range(2 * h + 2, 2 * h + 14);
            hg = $urandom_range(2 * h + 2, 2 * h + 8);
            if ($urandom_range(3) == 0)
            begin
                w = $urandom_range(4, 6);
                hg = $urandom_range(4, 6);
            end
            frames = $urandom_range(1, 2);
            steady = ($urandom_range(5) == 0);
            set_geometry(w, hg, h, d);
            cnt = frames * w * hg + $urandom_range(0, w);
            if (cnt > ITEM_TARGET - n_queued)
                cnt = ITEM_TARGET - n_queued;
            queue_pixels(w, cnt, 1'b1, 0);
            wait_drained();
        end
        steady = 1'b0;
        repeat (50) @(negedge clk);

        $display("Sent %0d pixel words in %0d phases, checked %0d disparity words.",
                 n_accepted, n_phases, n_results);
        $display("Covered clamped registers, window sizes 2..16, 1..32 offsets, stalls.");
        if (n_errors == 0 && disparity_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
